@@ sv/knns_pkg.sv @@
// shared types and constants for the k-nearest-neighbor search block
// no dependencies; used by every other file of the block except knns_ram
`default_nettype none

package knns_pkg;

  localparam int OP_W    = 2;
  localparam int COORD_W = 16;
  localparam int QIDX_W  = 8;
  localparam int NIDX_W  = 8;
  localparam int DIST_W  = 33;
  localparam int STAT_W  = 2;
  localparam int CFG_W   = 5;

  typedef logic [OP_W-1:0]   opcode_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam opcode_t OP_CLEAR  = 2'd0;
  localparam opcode_t OP_APPEND = 2'd1;
  localparam opcode_t OP_QUERY  = 2'd2;

  localparam status_t ST_VALID  = 2'd0;
  localparam status_t ST_EMPTY  = 2'd1;
  localparam status_t ST_BADIDX = 2'd2;

  localparam logic [CFG_W-1:0] K_RESET = 5'd8;

  // controller to datapath commands
  typedef struct packed {
    logic    clear;
    logic    append;
    logic    rd_en;
    logic    rd_query;
    logic    rd_skip;
    logic    list_clear;
    logic    emit;
    logic    resp;
    logic    last;
    status_t resp_status;
  } cmd_t;

endpackage

`default_nettype wire

@@ sv/knns_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module knns_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ sv/knns_ctrl.sv @@
// controller for the k-nearest-neighbor search: op decode, scan and emit sequencing
// depends on knns_pkg; drives knns_dpath through knns_pkg::cmd_t
`default_nettype none

module knns_ctrl #(
  parameter int MAX_POINTS = 256,
  parameter int MAX_K = 16,
  localparam int IDX_W = $clog2(MAX_POINTS),
  localparam int CNT_W = $clog2(MAX_POINTS + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire knns_pkg::opcode_t             in_opcode,
  input  wire logic [knns_pkg::QIDX_W-1:0]   in_qidx,
  input  wire logic                          cfg_we,
  input  wire logic [knns_pkg::CFG_W-1:0]    cfg_wdata,
  input  wire logic [CNT_W-1:0]              point_count,
  input  wire logic                          out_free,
  output knns_pkg::cmd_t                     cmd,
  output logic [IDX_W-1:0]                   rd_addr
);

  localparam int KW  = $clog2(MAX_K + 1);
  localparam int QW  = (knns_pkg::QIDX_W > CNT_W) ? knns_pkg::QIDX_W : CNT_W;
  localparam int MW0 = (CNT_W > KW) ? CNT_W : KW;
  localparam int MW  = (MW0 > knns_pkg::CFG_W) ? MW0 : knns_pkg::CFG_W;
  localparam logic [1:0] DRAIN_END = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_RESP, S_QRD, S_SCAN, S_DRAIN, S_EMIT
  } state_t;

  state_t                       state_r, state_nxt;
  logic [knns_pkg::CFG_W-1:0]   k_cfg_r;
  logic [IDX_W-1:0]             q_r, q_nxt;
  logic [KW-1:0]                kk_r, kk_nxt;
  logic [IDX_W-1:0]             scan_r, scan_nxt;
  logic [1:0]                   drain_r, drain_nxt;
  logic [KW-1:0]                emit_r, emit_nxt;
  knns_pkg::status_t            resp_st_r, resp_st_nxt;

  logic             accept;
  logic [QW-1:0]    q_ext;
  logic             bad_idx;
  logic [MW-1:0]    k_lim;
  logic [MW-1:0]    cnt_m1_w;
  logic [KW-1:0]    kk_new;
  logic [CNT_W-1:0] cnt_m1;
  logic [IDX_W-1:0] last_idx;
  logic             emit_last;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign q_ext     = QW'(in_qidx);
  assign bad_idx   = q_ext >= QW'(point_count);
  assign cnt_m1    = point_count - CNT_W'(1);
  assign last_idx  = cnt_m1[IDX_W-1:0];
  assign cnt_m1_w  = MW'(point_count) - MW'(1);
  assign emit_last = (emit_r == kk_r - KW'(1));

  // k capped by MAX_K and by the number of other points
  always_comb begin
    k_lim = MW'(k_cfg_r);
    if (k_lim > MW'(MAX_K)) begin
      k_lim = MW'(MAX_K);
    end
    if (k_lim > cnt_m1_w) begin
      k_lim = cnt_m1_w;
    end
    kk_new = k_lim[KW-1:0];
  end

  always_comb begin
    state_nxt   = state_r;
    q_nxt       = q_r;
    kk_nxt      = kk_r;
    scan_nxt    = scan_r;
    drain_nxt   = drain_r;
    emit_nxt    = emit_r;
    resp_st_nxt = resp_st_r;
    cmd         = '0;
    rd_addr     = scan_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_opcode)
            knns_pkg::OP_CLEAR: begin
              cmd.clear = 1'b1;
            end
            knns_pkg::OP_APPEND: begin
              cmd.append = 1'b1;
            end
            knns_pkg::OP_QUERY: begin
              q_nxt  = q_ext[IDX_W-1:0];
              kk_nxt = kk_new;
              if (bad_idx) begin
                resp_st_nxt = knns_pkg::ST_BADIDX;
                state_nxt   = S_RESP;
              end else if (kk_new == '0) begin
                resp_st_nxt = knns_pkg::ST_EMPTY;
                state_nxt   = S_RESP;
              end else begin
                state_nxt = S_QRD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RESP: begin
        if (out_free) begin
          cmd.resp        = 1'b1;
          cmd.last        = 1'b1;
          cmd.resp_status = resp_st_r;
          state_nxt       = S_IDLE;
        end
      end
      S_QRD: begin
        cmd.rd_en      = 1'b1;
        cmd.rd_query   = 1'b1;
        cmd.list_clear = 1'b1;
        rd_addr        = q_r;
        scan_nxt       = '0;
        state_nxt      = S_SCAN;
      end
      S_SCAN: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_skip = (scan_r == q_r);
        if (scan_r == last_idx) begin
          drain_nxt = '0;
          state_nxt = S_DRAIN;
        end else begin
          scan_nxt = scan_r + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        drain_nxt = drain_r + 2'd1;
        if (drain_r == DRAIN_END) begin
          emit_nxt  = '0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          cmd.last = emit_last;
          if (emit_last) begin
            state_nxt = S_IDLE;
          end else begin
            emit_nxt = emit_r + KW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_cfg_r <= knns_pkg::K_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        k_cfg_r <= cfg_wdata;
      end
    end
    q_r       <= q_nxt;
    kk_r      <= kk_nxt;
    scan_r    <= scan_nxt;
    drain_r   <= drain_nxt;
    emit_r    <= emit_nxt;
    resp_st_r <= resp_st_nxt;
  end

endmodule

`default_nettype wire

@@ sv/knns_dpath.sv @@
// datapath for the k-nearest-neighbor search: point store, distance pipeline,
// sorted best list and output register; depends on knns_pkg and knns_ram
`default_nettype none

module knns_dpath #(
  parameter int MAX_POINTS = 256,
  parameter int MAX_K = 16,
  parameter int COORD_BITS = 16,
  localparam int IDX_W = $clog2(MAX_POINTS),
  localparam int CNT_W = $clog2(MAX_POINTS + 1)
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire knns_pkg::cmd_t                 cmd,
  input  wire logic [IDX_W-1:0]               rd_addr,
  input  wire logic [knns_pkg::COORD_W-1:0]   in_x,
  input  wire logic [knns_pkg::COORD_W-1:0]   in_y,
  output logic [CNT_W-1:0]                    point_count,
  output logic                                out_free,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [knns_pkg::NIDX_W-1:0]         out_nidx,
  output logic [knns_pkg::DIST_W-1:0]         out_dist,
  output knns_pkg::status_t                   out_status,
  output logic                                out_last
);

  localparam int SW = (COORD_BITS < knns_pkg::COORD_W) ? COORD_BITS : knns_pkg::COORD_W;
  localparam int DW = 2 * SW + 1;
  localparam int NW = (IDX_W > knns_pkg::NIDX_W) ? IDX_W : knns_pkg::NIDX_W;

  // point store
  logic [CNT_W-1:0]  count_r;
  logic              wr_en;
  logic [2*SW-1:0]   ram_q;

  assign wr_en       = cmd.append && (count_r < CNT_W'(MAX_POINTS));
  assign point_count = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.clear) begin
      count_r <= '0;
    end else if (wr_en) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  knns_ram #(
    .WIDTH (2 * SW),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count_r[IDX_W-1:0]),
    .wdata ({in_y[SW-1:0], in_x[SW-1:0]}),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // distance pipeline
  logic             rdv_r, rdq_r;
  logic [IDX_W-1:0] rdi_r;
  logic [SW-1:0]    qx_r, qy_r;
  logic [SW:0]      dx, dy, ndx, ndy;
  logic [SW-1:0]    ax, ay;
  logic             p2_v_r;
  logic [IDX_W-1:0] p2_i_r;
  logic [2*SW-1:0]  sqx_r, sqy_r;
  logic             p3_v_r;
  logic [IDX_W-1:0] p3_i_r;
  logic [DW-1:0]    p3_d_r;

  assign dx  = {ram_q[SW-1], ram_q[SW-1:0]} - {qx_r[SW-1], qx_r};
  assign dy  = {ram_q[2*SW-1], ram_q[2*SW-1:SW]} - {qy_r[SW-1], qy_r};
  assign ndx = -dx;
  assign ndy = -dy;
  assign ax  = dx[SW] ? ndx[SW-1:0] : dx[SW-1:0];
  assign ay  = dy[SW] ? ndy[SW-1:0] : dy[SW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdv_r  <= 1'b0;
      rdq_r  <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
    end else begin
      rdv_r  <= cmd.rd_en && !cmd.rd_query && !cmd.rd_skip;
      rdq_r  <= cmd.rd_en && cmd.rd_query;
      p2_v_r <= rdv_r;
      p3_v_r <= p2_v_r;
    end
    rdi_r  <= rd_addr;
    if (rdq_r) begin
      qx_r <= ram_q[SW-1:0];
      qy_r <= ram_q[2*SW-1:SW];
    end
    p2_i_r <= rdi_r;
    sqx_r  <= {{SW{1'b0}}, ax} * {{SW{1'b0}}, ax};
    sqy_r  <= {{SW{1'b0}}, ay} * {{SW{1'b0}}, ay};
    p3_i_r <= p2_i_r;
    p3_d_r <= {1'b0, sqx_r} + {1'b0, sqy_r};
  end

  // sorted best list, one compare per cell, insert after equal distances
  logic [DW-1:0]    lst_d_r [MAX_K];
  logic [IDX_W-1:0] lst_i_r [MAX_K];
  logic             lst_v_r [MAX_K];
  logic             lt      [MAX_K];
  logic             ins_at  [MAX_K];
  logic [DW-1:0]    prv_d   [MAX_K];
  logic [IDX_W-1:0] prv_i   [MAX_K];
  logic             prv_v   [MAX_K];
  logic [DW-1:0]    nxt_d   [MAX_K];
  logic [IDX_W-1:0] nxt_i   [MAX_K];

  for (genvar j = 0; j < MAX_K; j++) begin : g_cell
    assign lt[j] = !lst_v_r[j] || (p3_d_r < lst_d_r[j]);
    if (j == 0) begin : g_head
      assign ins_at[j] = lt[j];
      assign prv_d[j]  = p3_d_r;
      assign prv_i[j]  = p3_i_r;
      assign prv_v[j]  = 1'b1;
    end else begin : g_body
      assign ins_at[j] = lt[j] && !lt[j-1];
      assign prv_d[j]  = lst_d_r[j-1];
      assign prv_i[j]  = lst_i_r[j-1];
      assign prv_v[j]  = lst_v_r[j-1];
    end
    if (j == MAX_K - 1) begin : g_tail
      assign nxt_d[j] = lst_d_r[j];
      assign nxt_i[j] = lst_i_r[j];
    end else begin : g_shift
      assign nxt_d[j] = lst_d_r[j+1];
      assign nxt_i[j] = lst_i_r[j+1];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_K; j++) begin
      if (!rst_n || cmd.list_clear) begin
        lst_v_r[j] <= 1'b0;
      end else if (p3_v_r && lt[j]) begin
        lst_v_r[j] <= ins_at[j] ? 1'b1 : prv_v[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_K; j++) begin
      if (p3_v_r) begin
        if (lt[j]) begin
          lst_d_r[j] <= ins_at[j] ? p3_d_r : prv_d[j];
          lst_i_r[j] <= ins_at[j] ? p3_i_r : prv_i[j];
        end
      end else if (cmd.emit) begin
        lst_d_r[j] <= nxt_d[j];
        lst_i_r[j] <= nxt_i[j];
      end
    end
  end

  // output register
  logic                        out_v_r;
  logic [knns_pkg::NIDX_W-1:0] out_nidx_r;
  logic [knns_pkg::DIST_W-1:0] out_dist_r;
  knns_pkg::status_t           out_st_r;
  logic                        out_last_r;
  logic [NW-1:0]               head_i_w;

  assign head_i_w = NW'(lst_i_r[0]);
  assign out_free = !out_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (cmd.emit || cmd.resp) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
    if (cmd.emit) begin
      out_nidx_r <= head_i_w[knns_pkg::NIDX_W-1:0];
      out_dist_r <= knns_pkg::DIST_W'(lst_d_r[0]);
      out_st_r   <= knns_pkg::ST_VALID;
      out_last_r <= cmd.last;
    end else if (cmd.resp) begin
      out_nidx_r <= '0;
      out_dist_r <= '0;
      out_st_r   <= cmd.resp_status;
      out_last_r <= cmd.last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_nidx   = out_nidx_r;
  assign out_dist   = out_dist_r;
  assign out_status = out_st_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

@@ sv/k_nearest_neighbor_search.sv @@
// clear and append are done while idle, as the transfer is taken; opcode 3 is accepted and dropped
// a query loads the query point, then scans with one ram read per stored point into a
// three-stage distance pipeline and, once it drains, emits one result per cycle while the
// output is not stalled, for min(k, MAX_K, point_count - 1) results; a bad index or zero k gives one status-only answer
// synchronous active-low reset: store empty, k = 8, output idle; store contents
// are undefined until written
`default_nettype none

module k_nearest_neighbor_search #(
  parameter int MAX_POINTS = 256,
  parameter int MAX_K = 16,
  parameter int COORD_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // point_x[15:0], point_y[31:16], query_index[39:32]
  input  wire logic [1:0]  in_tuser,   // opcode[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // neighbor_index[7:0], distance_sq[40:8], zero[47:41]
  output logic [1:0]       out_tuser,  // status[1:0]
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_wdata   // neighbor_count[4:0]
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  knns_pkg::cmd_t              cmd;
  logic [IDX_W-1:0]            rd_addr;
  logic [CNT_W-1:0]            point_count;
  logic                        out_free;
  logic [knns_pkg::NIDX_W-1:0] out_nidx;
  logic [knns_pkg::DIST_W-1:0] out_dist;

  knns_ctrl #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_K      (MAX_K)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_opcode   (in_tuser),
    .in_qidx     (in_tdata[39:32]),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .point_count (point_count),
    .out_free    (out_free),
    .cmd         (cmd),
    .rd_addr     (rd_addr)
  );

  knns_dpath #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_K      (MAX_K),
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .in_x        (in_tdata[15:0]),
    .in_y        (in_tdata[31:16]),
    .point_count (point_count),
    .out_free    (out_free),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_nidx    (out_nidx),
    .out_dist    (out_dist),
    .out_status  (out_tuser),
    .out_last    (out_tlast)
  );

  assign out_tdata = {7'b0, out_dist, out_nidx};

endmodule

`default_nettype wire

@@ sv/knns_checker.sv @@
// port-level assertions for k_nearest_neighbor_search, bound to the top level
// depends on knns_pkg
`default_nettype none

module knns_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [1:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != knns_pkg::ST_VALID) |-> out_tlast)
    else $error("status result without tlast");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != knns_pkg::ST_VALID) |-> (out_tdata == '0))
    else $error("status result with nonzero data");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == knns_pkg::OP_QUERY) |=> !in_tready)
    else $error("input taken right after a query transfer");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

endmodule

bind k_nearest_neighbor_search knns_checker u_knns_checker (.*);

`default_nettype wire

@@ sim/k_nearest_neighbor_search_test.sv @@
// self-checking testbench for the k-nearest-neighbor search block
// drives clear/append/query transfers with random bursts and output stalls and checks
// every result against a built-in predictor; depends on knns_pkg and the block's rtl

module k_nearest_neighbor_search_test;

  localparam int STORE_DEPTH   = 256;
  localparam int MAX_NEIGHBORS = 16;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_ITEMS   = 8;
  localparam knns_pkg::opcode_t OP_UNUSED = 2'd3;

  typedef struct {
    knns_pkg::opcode_t op;
    logic [15:0]       x;
    logic [15:0]       y;
    logic [7:0]        qidx;
  } search_request_t;

  typedef struct {
    logic [7:0]        nidx;
    logic [32:0]       dsq;
    knns_pkg::status_t st;
    logic              last;
  } neighbor_result_t;

  class neighbor_scoreboard;
    logic signed [15:0] x_mem [STORE_DEPTH];
    logic signed [15:0] y_mem [STORE_DEPTH];
    int unsigned npoints;
    int unsigned k_value;
    int unsigned errors;
    neighbor_result_t pending_neighbors[$];

    function new();
      npoints = 0;
      k_value = knns_pkg::K_RESET;
      errors  = 0;
    endfunction

    function void set_k(logic [4:0] v);
      k_value = v;
    endfunction

    function int pending();
      return pending_neighbors.size();
    endfunction

    function void add_expect(logic [7:0] nidx, logic [32:0] dsq, knns_pkg::status_t st,
                             logic last);
      neighbor_result_t r;
      r.nidx = nidx;
      r.dsq  = dsq;
      r.st   = st;
      r.last = last;
      pending_neighbors = {pending_neighbors, r};
    endfunction

    function void predict_neighbors(int unsigned q);
      longint unsigned best_d [MAX_NEIGHBORS];
      int unsigned     best_i [MAX_NEIGHBORS];
      int unsigned     kk, filled, p, j;
      longint          dx, dy;
      longint unsigned d;
      if (q >= npoints) begin
        add_expect(8'd0, 33'd0, knns_pkg::ST_BADIDX, 1'b1);
        return;
      end
      kk = (k_value > MAX_NEIGHBORS) ? MAX_NEIGHBORS : k_value;
      if (kk > npoints - 1) kk = npoints - 1;
      if (kk == 0) begin
        add_expect(8'd0, 33'd0, knns_pkg::ST_EMPTY, 1'b1);
        return;
      end
      filled = 0;
      for (int unsigned i = 0; i < npoints; i++) begin
        if (i == q) continue;
        dx = longint'(x_mem[i]) - longint'(x_mem[q]);
        dy = longint'(y_mem[i]) - longint'(y_mem[q]);
        d  = longint'(dx * dx + dy * dy);
        // equal distances stay behind earlier entries
        p = 0;
        while (p < filled && best_d[p] <= d) p++;
        if (p >= kk) continue;
        j = (filled < kk) ? filled : kk - 1;
        while (j > p) begin
          best_d[j] = best_d[j-1];
          best_i[j] = best_i[j-1];
          j--;
        end
        best_d[p] = d;
        best_i[p] = i;
        if (filled < kk) filled++;
      end
      for (int unsigned i = 0; i < filled; i++)
        add_expect(best_i[i][7:0], best_d[i][32:0], knns_pkg::ST_VALID, i + 1 == filled);
    endfunction

    function void note_input(search_request_t req);
      case (req.op)
        knns_pkg::OP_CLEAR: npoints = 0;
        knns_pkg::OP_APPEND: begin
          if (npoints < STORE_DEPTH) begin
            x_mem[npoints] = req.x;
            y_mem[npoints] = req.y;
            npoints++;
          end
        end
        knns_pkg::OP_QUERY: predict_neighbors(req.qidx);
        default: ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
    endtask

    task check_result(neighbor_result_t got);
      neighbor_result_t want;
      if (pending_neighbors.size() == 0) begin
        report($sformatf("unexpected result index %0d status %0d", got.nidx, got.st));
        return;
      end
      want = pending_neighbors.pop_front();
      if (got.nidx !== want.nidx)
        report($sformatf("neighbor_index got %0d expected %0d", got.nidx, want.nidx));
      if (got.dsq !== want.dsq)
        report($sformatf("distance_sq got %0d expected %0d", got.dsq, want.dsq));
      if (got.st !== want.st)
        report($sformatf("status got %0d expected %0d", got.st, want.st));
      if (got.last !== want.last)
        report($sformatf("last got %0d expected %0d", got.last, want.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;

  neighbor_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  logic [5:0]  rx_phase = '0;
  logic [1:0]  rx_mode = '0;

  k_nearest_neighbor_search i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: check each transfer, stall on a pattern picked anew each time rx_phase wraps
  always @(posedge clk) begin
    neighbor_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.nidx = out_tdata[7:0];
      got.dsq  = out_tdata[40:8];
      got.st   = out_tuser;
      got.last = out_tlast;
      sb.check_result(got);
    end
    rx_phase <= rx_phase + 6'd1;
    if (rx_phase == 6'd0) rx_mode <= 2'($urandom_range(0, 3));
    case (rx_mode)
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= ($urandom_range(0, 3) != 0);
      2'd2: out_tready <= (rx_phase[1:0] != 2'b11);
      default: out_tready <= ($urandom_range(0, 1) == 1);
    endcase
  end

  function automatic search_request_t make_request(knns_pkg::opcode_t op, logic [15:0] x,
                                                   logic [15:0] y, logic [7:0] qidx);
    search_request_t r;
    r.op   = op;
    r.x    = x;
    r.y    = y;
    r.qidx = qidx;
    return r;
  endfunction

  function automatic logic [15:0] random_coord();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 12) return 16'($urandom);
    if (r < 17) return 16'(int'($urandom_range(0, 6)) - 3);
    case ($urandom_range(0, 3))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      default: return 16'h0000;
    endcase
  endfunction

  function automatic logic [7:0] random_query_index();
    if (sb.npoints > 0 && $urandom_range(0, 6) != 0)
      return 8'($urandom_range(0, sb.npoints - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic search_request_t random_request();
    int unsigned r;
    knns_pkg::opcode_t op;
    r = $urandom_range(0, 99);
    if (r < 2) op = knns_pkg::OP_CLEAR;
    else if (r < 5) op = OP_UNUSED;
    else if (r < 62) op = knns_pkg::OP_APPEND;
    else op = knns_pkg::OP_QUERY;
    return make_request(op, random_coord(), random_coord(), random_query_index());
  endfunction

  task automatic send_item(search_request_t req);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 12);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= req.op;
    in_tdata  <= {req.qidx, req.y, req.x};
    do @(posedge clk); while (!in_tready);
    sb.note_input(req);
  endtask

  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_k(logic [4:0] v);
    wait_quiet();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_k(v);
  endtask

  task automatic send_query(logic [7:0] qidx);
    send_item(make_request(knns_pkg::OP_QUERY, 16'h0, 16'h0, qidx));
  endtask

  task automatic send_append(logic [15:0] x, logic [15:0] y);
    send_item(make_request(knns_pkg::OP_APPEND, x, y, 8'h0));
  endtask

  initial begin
    logic [4:0] phase_k [8];
    phase_k = '{5'd16, 5'd3, 5'd31, 5'd0, 5'd17, 5'd0, 5'd2, 5'd8};
    phase_k[5] = 5'($urandom_range(0, 31));
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_query(8'd0);
    send_item(make_request(OP_UNUSED, 16'hffff, 16'hffff, 8'hff));
    send_append(16'h7fff, 16'h7fff);
    send_append(16'h8000, 16'h8000);
    send_append(16'h0000, 16'h0000);
    send_append(16'hffff, 16'h0001);
    send_append(16'h0001, 16'hffff);
    send_append(16'h7fff, 16'h8000);
    send_append(16'h0000, 16'h0000);
    send_append(16'h8000, 16'h7fff);
    send_query(8'd0);
    send_query(8'd1);
    send_query(8'd4);
    send_query(8'd8);
    send_query(8'd255);
    send_item(make_request(OP_UNUSED, 16'h0, 16'h0, 8'd0));
    send_item(make_request(knns_pkg::OP_CLEAR, 16'h0, 16'h0, 8'd0));
    send_query(8'd0);
    write_k(5'd0);
    send_append(16'h1234, 16'hedcb);
    send_query(8'd0);
    write_k(5'd1);
    send_query(8'd0);
    send_append(16'h1234, 16'hedcb);
    send_query(8'd1);
    send_query(8'd0);

    foreach (phase_k[p]) begin
      write_k(phase_k[p]);
      repeat (PHASE_ITEMS) send_item(random_request());
    end

    // fill the store, then push appends into a full store
    write_k(5'd16);
    while (sb.npoints < STORE_DEPTH) begin
      if ($urandom_range(0, 19) < 19) send_append(random_coord(), random_coord());
      else send_query(random_query_index());
    end
    repeat (3) send_append(random_coord(), random_coord());
    send_query(8'd255);
    send_query(8'd0);
    repeat (4) send_query(random_query_index());

    wait_quiet();
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/knns_pkg.sv
sv/knns_ram.sv
sv/knns_ctrl.sv
sv/knns_dpath.sv
sv/k_nearest_neighbor_search.sv
sv/knns_checker.sv
sim/k_nearest_neighbor_search_test.sv
